FILE: sv/pwfbm_pkg.sv
// Shared constants, types and helper functions for the periodic inverted Worley fBm unit.
// No dependencies; imported by every module of the block.
package pwfbm_pkg;

	localparam int COORD_FRAC_BITS = 16;
	localparam int MAX_OCTAVES     = 3;
	localparam int MAX_BASE_FREQ   = 64;

	localparam int CELL_W  = 8;
	localparam int FREQ_W  = 9;
	localparam int D2_W    = 34;
	localparam int INV_W   = 17;
	localparam int NOISE_W = 16;
	localparam int MIX_W   = 21;
	localparam int QUOT_W  = 20;
	localparam int RECIP_W = 26;
	localparam int RECIP_SHIFT = 25;

	localparam logic [31:0] HASH_MUL1 = 32'h85ebca6b;
	localparam logic [31:0] HASH_MUL2 = 32'hc2b2ae35;
	localparam logic [31:0] SEED_MUL  = 32'd2654435761;
	localparam logic [31:0] SEED_STEP = 32'd6151;
	localparam logic [31:0] AXIS_PRIME [3] = '{32'd73856093, 32'd19349663, 32'd83492791};

	localparam logic [D2_W-1:0]  D2_START = 34'h3_0000_0000;
	localparam logic [INV_W-1:0] ONE_Q16  = 17'h10000;

	// register indexes on the configuration port
	localparam logic [1:0] REG_BASE_FREQ = 2'd0;
	localparam logic [1:0] REG_OCT_COUNT = 2'd1;
	localparam logic [1:0] REG_SEED      = 2'd2;

	localparam logic [MIX_W-1:0] OCT_WEIGHT [3] = '{21'd12, 21'd3, 21'd1};

	typedef logic [COORD_FRAC_BITS-1:0] coord_t;
	typedef logic [D2_W-1:0]            dist2_t;
	typedef logic [INV_W-1:0]           inv_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [31:0]       seed_term;
	} oct_cfg_t;

	typedef struct packed {
		logic [19:0] rem;
		logic [15:0] root;
	} sqrt_st_t;

	// one digit of the restoring square root
	function automatic sqrt_st_t sqrt_step(input sqrt_st_t st, input logic [1:0] pair);
		logic [19:0] r;
		logic [19:0] trial;
		sqrt_st_t    res;
		r     = {st.rem[17:0], pair};
		trial = {2'b00, st.root, 2'b01};
		if (r >= trial) begin
			res.rem  = r - trial;
			res.root = {st.root[14:0], 1'b1};
		end else begin
			res.rem  = r;
			res.root = {st.root[14:0], 1'b0};
		end
		return res;
	endfunction

	function automatic dist2_t min3(input dist2_t a, input dist2_t b, input dist2_t c);
		dist2_t m;
		m = (b < a) ? b : a;
		return (c < m) ? c : m;
	endfunction

	function automatic logic [MIX_W-1:0] weight_total(input logic [1:0] n);
		logic [MIX_W-1:0] w;
		case (n)
			2'd2:    w = OCT_WEIGHT[0] + OCT_WEIGHT[1];
			2'd3:    w = OCT_WEIGHT[0] + OCT_WEIGHT[1] + OCT_WEIGHT[2];
			default: w = OCT_WEIGHT[0];
		endcase
		return w;
	endfunction

	// ceil(2^25/3) for /24 after >>3, ceil(2^25/15) for /30 after >>1, 2^25 for /32 after >>5
	function automatic logic [RECIP_W-1:0] div_mult(input logic [1:0] n);
		logic [RECIP_W-1:0] m;
		case (n)
			2'd2:    m = 26'd2236963;
			2'd3:    m = 26'd33554432;
			default: m = 26'd11184811;
		endcase
		return m;
	endfunction

endpackage

FILE: sv/pwfbm_cell.sv
// One lattice cell: hash of the wrapped cell, feature point and clamped squared distance.
// Depends on pwfbm_pkg. Four register stages (s4..s7).
module pwfbm_cell (
	input  logic                            clk,
	input  logic                            en,
	input  logic [31:0]                     px,
	input  logic [31:0]                     py,
	input  logic [31:0]                     pz,
	input  logic [31:0]                     seed_term,
	input  pwfbm_pkg::coord_t               fx,
	input  pwfbm_pkg::coord_t               fy,
	input  pwfbm_pkg::coord_t               fz,
	input  logic signed [1:0]               dx,
	input  logic signed [1:0]               dy,
	input  logic signed [1:0]               dz,
	output pwfbm_pkg::dist2_t               d2_s7
);
	import pwfbm_pkg::*;

	logic [31:0] mix0;
	logic [31:0] mix1;
	logic [31:0] hash;
	logic [31:0] v1_s4;
	logic [31:0] v2_s5;
	logic [D2_W-1:0] sq [3];
	logic [D2_W-1:0] sq_s6 [3];
	logic [D2_W+1:0] sum;

	always_comb begin
		logic signed [18:0] off;
		logic signed [18:0] del;
		logic signed [37:0] prd;
		logic signed [1:0]  d_a;
		coord_t             f_a;
		mix0 = px ^ py ^ pz ^ seed_term;
		mix0 = mix0 ^ (mix0 >> 16);
		mix1 = v1_s4 ^ (v1_s4 >> 13);
		hash = v2_s5 ^ (v2_s5 >> 16);
		for (int a = 0; a < 3; a++) begin
			d_a = (a == 0) ? dx : ((a == 1) ? dy : dz);
			f_a = (a == 0) ? fx : ((a == 1) ? fy : fz);
			// neighbour step of -1, 0 or +1 cell in Q.16
			del = {d_a[1], d_a, 16'd0};
			off = del + $signed({3'b000, hash[10*a +: 10], 6'd0})
				- $signed({3'b000, f_a});
			prd = 38'(off) * 38'(off);
			sq[a] = prd[D2_W-1:0];
		end
		sum = 36'(sq_s6[0]) + 36'(sq_s6[1]) + 36'(sq_s6[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v1_s4 <= mix0 * HASH_MUL1;
			v2_s5 <= mix1 * HASH_MUL2;
			for (int a = 0; a < 3; a++)
				sq_s6[a] <= sq[a];
			d2_s7 <= (sum >= 36'(D2_START)) ? D2_START : sum[D2_W-1:0];
		end
	end

endmodule

FILE: sv/pwfbm_isqrt.sv
// Pipelined integer square root: four stages of four digits each, saturating at 1.0 in Q.16.
// Depends on pwfbm_pkg.
module pwfbm_isqrt (
	input  logic              clk,
	input  logic              en,
	input  pwfbm_pkg::dist2_t best,
	output pwfbm_pkg::inv_t   root_q16
);
	import pwfbm_pkg::*;

	// st_s[k] holds the partial root after stage k
	sqrt_st_t    st_next [4];
	sqrt_st_t    st_s [4];
	logic [31:0] val_s [3];
	logic        sat_s [4];

	always_comb begin
		sqrt_st_t    st;
		logic [31:0] v;
		for (int k = 0; k < 4; k++) begin
			st = (k == 0) ? '0 : st_s[(k == 0) ? 0 : k - 1];
			v  = (k == 0) ? best[31:0] : val_s[(k == 0) ? 0 : k - 1];
			for (int j = 0; j < 4; j++)
				st = sqrt_step(st, v[2*(15 - 4*k - j) +: 2]);
			st_next[k] = st;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++)
				st_s[k] <= st_next[k];
			val_s[0] <= best[31:0];
			sat_s[0] <= |best[D2_W-1:32];
			for (int k = 1; k < 3; k++)
				val_s[k] <= val_s[k-1];
			for (int k = 1; k < 4; k++)
				sat_s[k] <= sat_s[k-1];
		end
	end

	assign root_q16 = sat_s[3] ? ONE_Q16 : {1'b0, st_s[3].root};

endmodule

FILE: sv/pwfbm_octave.sv
// One octave: cell/fraction split, wrapped neighbour products, 27 cells, min tree, square root.
// Depends on pwfbm_pkg, pwfbm_cell and pwfbm_isqrt. Input at s1, inverted distance after s14.
module pwfbm_octave (
	input  logic                   clk,
	input  logic                   en,
	input  logic [2:0][15:0]       pos_s1,
	input  pwfbm_pkg::oct_cfg_t    cfg,
	output pwfbm_pkg::inv_t        inv
);
	import pwfbm_pkg::*;

	logic [CELL_W-1:0] cell_s2 [3];
	coord_t            frac_s2 [3];
	coord_t            frac_s3 [3];
	coord_t            frac_s4 [3];
	coord_t            frac_s5 [3];
	logic [31:0]       prod_s3 [3][3];
	logic [CELL_W-1:0] wrap [3][3];
	logic [24:0]       u [3];
	dist2_t            d2_s7 [27];
	dist2_t            m_s8 [9];
	dist2_t            m_s9 [3];
	dist2_t            best_s10;
	inv_t              root_q16;

	always_comb begin
		logic [CELL_W-1:0] c;
		for (int a = 0; a < 3; a++) begin
			u[a] = 25'(pos_s1[a]) * 25'(cfg.freq);
			c = cell_s2[a];
			// neighbours wrap around the lattice period
			wrap[a][0] = (c == '0) ? CELL_W'(cfg.freq - 9'd1) : c - 8'd1;
			wrap[a][1] = c;
			wrap[a][2] = ((9'(c) + 9'd1) == cfg.freq) ? '0 : c + 8'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				cell_s2[a] <= u[a][23:16];
				frac_s2[a] <= u[a][15:0];
				frac_s3[a] <= frac_s2[a];
				frac_s4[a] <= frac_s3[a];
				frac_s5[a] <= frac_s4[a];
				for (int d = 0; d < 3; d++)
					prod_s3[a][d] <= 32'(wrap[a][d]) * AXIS_PRIME[a];
			end
			for (int g = 0; g < 9; g++)
				m_s8[g] <= min3(d2_s7[3*g], d2_s7[3*g+1], d2_s7[3*g+2]);
			for (int g = 0; g < 3; g++)
				m_s9[g] <= min3(m_s8[3*g], m_s8[3*g+1], m_s8[3*g+2]);
			best_s10 <= min3(m_s9[0], m_s9[1], m_s9[2]);
		end
	end

	for (genvar gz = 0; gz < 3; gz++) begin : g_z
		for (genvar gy = 0; gy < 3; gy++) begin : g_y
			for (genvar gx = 0; gx < 3; gx++) begin : g_x
				pwfbm_cell u_cell (
					.clk       (clk),
					.en        (en),
					.px        (prod_s3[0][gx]),
					.py        (prod_s3[1][gy]),
					.pz        (prod_s3[2][gz]),
					.seed_term (cfg.seed_term),
					.fx        (frac_s5[0]),
					.fy        (frac_s5[1]),
					.fz        (frac_s5[2]),
					.dx        (2'(gx - 1)),
					.dy        (2'(gy - 1)),
					.dz        (2'(gz - 1)),
					.d2_s7     (d2_s7[gz*9 + gy*3 + gx])
				);
			end
		end
	end

	pwfbm_isqrt u_isqrt (
		.clk      (clk),
		.en       (en),
		.best     (best_s10),
		.root_q16 (root_q16)
	);

	assign inv = ONE_Q16 - root_q16;

endmodule

FILE: sv/pwfbm_mix.sv
// Octave weighting and rounded division by twice the weight sum (reciprocal multiply).
// Depends on pwfbm_pkg. Stages s15 and s16.
module pwfbm_mix (
	input  logic                clk,
	input  logic                en,
	input  logic [2:0][16:0]    inv,
	input  logic [1:0]          oct_n,
	output logic [15:0]         noise
);
	import pwfbm_pkg::*;

	logic [MIX_W-1:0]          num;
	logic [MIX_W-1:0]          x_s15;
	logic [QUOT_W-1:0]         y;
	logic [QUOT_W+RECIP_W-1:0] prod_s16;

	always_comb begin
		num = MIX_W'(inv[0]) * OCT_WEIGHT[0] + weight_total(oct_n);
		if (oct_n >= 2'd2)
			num = num + MIX_W'(inv[1]) * OCT_WEIGHT[1];
		if (oct_n == 2'd3)
			num = num + MIX_W'(inv[2]) * OCT_WEIGHT[2];
		case (oct_n)
			2'd2:    y = QUOT_W'(x_s15 >> 1);
			2'd3:    y = QUOT_W'(x_s15 >> 5);
			default: y = QUOT_W'(x_s15 >> 3);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s15    <= num;
			prod_s16 <= (QUOT_W+RECIP_W)'(y) * (QUOT_W+RECIP_W)'(div_mult(oct_n));
		end
	end

	assign noise = prod_s16[RECIP_SHIFT +: NOISE_W];

endmodule

FILE: sv/periodic_inverted_worley_fbm_unit.sv
// Tileable inverted Worley noise, one to three octaves, one sample per unstalled clock.
// Depends on pwfbm_pkg, pwfbm_octave and pwfbm_mix.
//
// Usage:
//   s_axis carries one point: pos_x, pos_y, pos_z as Q0.16 fractions of the volume.
//   m_axis returns noise_value, unsigned Q1.15 (32768 is 1.0).
//   cfg writes base_frequency (index 0), octave_count (1) and noise_seed (2);
//   other indexes are ignored. Write only while no sample is in flight.
// Throughput: one sample per cycle unless stalled; all 81 cell hashes of a sample are
//   evaluated in parallel, so nothing in the datapath is shared between samples.
// Pipeline: each sample passes through 17 register stages on its way to m_axis
//   (input, lattice split, wrap, hash x2, squares, distance sum,
//   three-level min tree, four square-root stages, weighting, reciprocal multiply, output).
// Reset: arst_n clears all valid flags and loads the register defaults
//   (frequency 4, three octaves, seed 2).
// Back-pressure: the pipeline advances whenever the output stage is empty or being
//   taken; while the receiver stalls a full output, every stage holds and s_axis_tready
//   drops, so no sample is lost or repeated. Bubbles drain freely.
module periodic_inverted_worley_fbm_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // pos_x [15:0], pos_y [31:16], pos_z [47:32]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // noise_value [15:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import pwfbm_pkg::*;

	localparam int DEPTH = 17;

	logic [6:0]        base_freq_q;
	logic [1:0]        oct_count_q;
	logic [31:0]       seed_q;
	logic [31:0]       seed_term_q [3];
	logic [DEPTH:1]    vld_q;
	logic              en;
	logic [2:0][15:0]  pos_s1;
	logic [6:0]        freq_eff;
	logic [1:0]        oct_n;
	logic [2:0][16:0]  inv;
	logic [15:0]       noise;
	logic [15:0]       noise_s17;
	oct_cfg_t          oct_cfg [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_freq_q <= 7'd4;
			oct_count_q <= 2'd3;
			seed_q      <= 32'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BASE_FREQ: base_freq_q <= cfg_data[6:0];
				REG_OCT_COUNT: oct_count_q <= cfg_data[1:0];
				REG_SEED:      seed_q      <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_comb begin
		if (base_freq_q == '0)
			freq_eff = 7'd1;
		else if (base_freq_q > 7'(MAX_BASE_FREQ))
			freq_eff = 7'(MAX_BASE_FREQ);
		else
			freq_eff = base_freq_q;
		oct_n = (oct_count_q == '0) ? 2'd1 : oct_count_q;
		for (int i = 0; i < 3; i++) begin
			oct_cfg[i].freq      = FREQ_W'(freq_eff) << i;
			oct_cfg[i].seed_term = seed_term_q[i];
		end
	end

	// seed product per octave, registered from the seed register
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			seed_term_q[i] <= (seed_q + SEED_STEP * 32'(i)) * SEED_MUL;
	end

	assign en            = !vld_q[DEPTH] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[DEPTH];
	assign m_axis_tdata  = noise_s17;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[DEPTH-1:1], s_axis_tvalid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1[0] <= s_axis_tdata[15:0];
			pos_s1[1] <= s_axis_tdata[31:16];
			pos_s1[2] <= s_axis_tdata[47:32];
			noise_s17 <= noise;
		end
	end

	for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
		pwfbm_octave u_octave (
			.clk    (clk),
			.en     (en),
			.pos_s1 (pos_s1),
			.cfg    (oct_cfg[o]),
			.inv    (inv[o])
		);
	end

	pwfbm_mix u_mix (
		.clk   (clk),
		.en    (en),
		.inv   (inv),
		.oct_n (oct_n),
		.noise (noise)
	);

endmodule
